/* src/order_statistic_multiset_core_assert.svh */
// Assertion macros used by the checker file osm_checker.sv.
`ifndef ORDER_STATISTIC_MULTISET_CORE_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_CORE_ASSERT_SVH

// Same-cycle implication, clocked by clk_i, off while rst_ni is low.
`define OSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/osm_pkg.sv */
// ----------------------------------------------------------------------------
// osm_pkg
// Types, constants and tree-address helpers of the order statistic multiset.
// ----------------------------------------------------------------------------
package osm_pkg;

  localparam int DIGIT_BITS = 4;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 20;

  localparam int RADIX     = 1 << DIGIT_BITS;
  localparam int LEVELS    = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam longint TREE_SIZE =
      ((64'd1 << (DIGIT_BITS * (LEVELS + 1))) - RADIX) / (RADIX - 1);
  localparam int ADDR_W    = $clog2(TREE_SIZE);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W     = COUNT_BITS + 1;
  localparam int POS_W     = 21;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;

  localparam logic [CNT_W-1:0]    CAPACITY  = CNT_W'(1) << COUNT_BITS;
  localparam logic [KEY_BITS-1:0] SIGN_MASK = KEY_BITS'(1) << (KEY_BITS - 1);
  localparam logic [ADDR_W-1:0]   LAST_NODE = ADDR_W'(TREE_SIZE - 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_RANK   = 3'd2,
    OP_SELECT = 3'd3,
    OP_PRED   = 3'd4,
    OP_SUCC   = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // First node index of a tree level.
  function automatic logic [ADDR_W-1:0] level_base(logic [LVL_W-1:0] lvl);
    longint base;
    longint width;
    base  = 0;
    width = 1;
    for (int i = 0; i < LEVELS; i++) begin
      if (i < int'(lvl)) begin
        width = width << DIGIT_BITS;
        base  = base + width;
      end
    end
    return ADDR_W'(base);
  endfunction

  // Bit position of the digit of a level.
  function automatic int level_shift(logic [LVL_W-1:0] lvl);
    return DIGIT_BITS * (LEVELS - 1 - int'(lvl));
  endfunction

  function automatic logic [DIGIT_BITS-1:0] key_digit(logic [KEY_BITS-1:0] w,
                                                      logic [LVL_W-1:0] lvl);
    longint v;
    v = longint'(w) >> level_shift(lvl);
    return DIGIT_BITS'(v);
  endfunction

  // Node holding digit dig under the prefix of w above level lvl.
  function automatic logic [ADDR_W-1:0] node_addr(logic [KEY_BITS-1:0] w,
                                                  logic [LVL_W-1:0] lvl,
                                                  logic [DIGIT_BITS-1:0] dig);
    longint parent;
    parent = longint'(w) >> (level_shift(lvl) + DIGIT_BITS);
    return level_base(lvl) + ADDR_W'((parent << DIGIT_BITS) + longint'(dig));
  endfunction

endpackage

/* src/order_statistic_multiset_core.sv */
// ----------------------------------------------------------------------------
// order_statistic_multiset_core
// Ordered multiset of signed keys kept as a radix counting tree in one RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o   | operation, key, position
//  out     | output    | out_valid_o/out_stall_i | found_key, rank, status
//
// One operation at a time; every node access is a registered RAM read
// followed by a use state. After reset a clearing pass writes all 69904
// counters with input stalled. A new operation is taken while the last
// result still waits; a stalled result holds the following one in S_FIN.
module order_statistic_multiset_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [osm_pkg::OP_W-1:0]               in_operation_i,
  input  logic signed [osm_pkg::KEY_BITS-1:0]    in_key_i,
  input  logic [osm_pkg::POS_W-1:0]              in_position_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [osm_pkg::KEY_BITS-1:0]    out_found_key_o,
  output logic [osm_pkg::POS_W-1:0]              out_rank_o,
  output logic [osm_pkg::STAT_W-1:0]             out_status_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RMW_RD, S_RMW_WR, S_ER_RD, S_ER_CHK,
    S_LESS_RD, S_LESS_ACC, S_LEAF_RD, S_LEAF_ACC, S_SEL_RD, S_SEL_USE, S_FIN
  } state_e;

  localparam logic [osm_pkg::LVL_W-1:0] LAST_LVL = osm_pkg::LVL_W'(osm_pkg::LEVELS - 1);
  localparam logic [osm_pkg::DIGIT_BITS-1:0] DIG_TOP = osm_pkg::DIGIT_BITS'(osm_pkg::RADIX - 1);
  localparam logic [osm_pkg::DIGIT_BITS-1:0] DIG_LAST_RD =
      osm_pkg::DIGIT_BITS'(osm_pkg::RADIX - 2);

  state_e                              state_q;
  osm_pkg::op_e                        op_q;
  logic [osm_pkg::KEY_BITS-1:0]        u_q;
  logic [osm_pkg::KEY_BITS-1:0]        prefix_q;
  logic [osm_pkg::POS_W-1:0]           pos_q;
  logic [osm_pkg::CNT_W-1:0]           k_q;
  logic [osm_pkg::CNT_W-1:0]           acc_q;
  logic [osm_pkg::CNT_W-1:0]           total_q;
  logic [osm_pkg::LVL_W-1:0]           lvl_q;
  logic [osm_pkg::DIGIT_BITS-1:0]      dig_q;
  logic [osm_pkg::ADDR_W-1:0]          clr_q;
  logic [osm_pkg::KEY_BITS-1:0]        res_key_q;
  logic [osm_pkg::POS_W-1:0]           res_rank_q;
  logic [osm_pkg::STAT_W-1:0]          res_status_q;
  logic                                out_valid_q;
  logic [osm_pkg::KEY_BITS-1:0]        out_key_q;
  logic [osm_pkg::POS_W-1:0]           out_rank_q;
  logic [osm_pkg::STAT_W-1:0]          out_status_q;

  // counter RAM
  logic [osm_pkg::CNT_W-1:0]           mem [osm_pkg::TREE_SIZE];
  logic [osm_pkg::CNT_W-1:0]           rdata_q;
  logic [osm_pkg::ADDR_W-1:0]          node;
  logic [osm_pkg::ADDR_W-1:0]          waddr;
  logic [osm_pkg::CNT_W-1:0]           wdata;
  logic                                we;

  logic [osm_pkg::DIGIT_BITS-1:0]      udig;
  logic [osm_pkg::DIGIT_BITS-1:0]      adig;
  logic [osm_pkg::KEY_BITS-1:0]        aw;
  logic [osm_pkg::CNT_W-1:0]           leaf_sum;
  logic                                pick;
  logic [osm_pkg::DIGIT_BITS-1:0]      pick_dig;
  logic [osm_pkg::KEY_BITS-1:0]        next_prefix;
  logic                                up;

  assign udig = osm_pkg::key_digit(u_q, lvl_q);
  assign up   = (op_q == osm_pkg::OP_INSERT);

  always_comb begin
    aw   = u_q;
    adig = dig_q;
    unique case (state_q)
      S_RMW_RD, S_RMW_WR, S_ER_RD, S_LEAF_RD: adig = udig;
      S_SEL_RD:                               aw   = prefix_q;
      default: ;
    endcase
  end

  assign node  = osm_pkg::node_addr(aw, lvl_q, adig);
  assign we    = (state_q == S_CLEAR) || (state_q == S_RMW_WR);
  assign waddr = (state_q == S_CLEAR) ? clr_q : node;
  assign wdata = (state_q == S_CLEAR) ? '0 :
                 (up ? rdata_q + osm_pkg::CNT_W'(1) : rdata_q - osm_pkg::CNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[node];
  end

  assign leaf_sum = acc_q + rdata_q;

  // select: stop at this digit when k fits, or when only the top digit is left
  always_comb begin
    pick     = 1'b0;
    pick_dig = dig_q;
    if (k_q <= rdata_q) begin
      pick = 1'b1;
    end else if (dig_q == DIG_LAST_RD) begin
      pick     = 1'b1;
      pick_dig = DIG_TOP;
    end
    next_prefix = prefix_q |
        (osm_pkg::KEY_BITS'(pick_dig) << osm_pkg::level_shift(lvl_q));
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      op_q         <= osm_pkg::OP_INSERT;
      u_q          <= '0;
      prefix_q     <= '0;
      pos_q        <= '0;
      k_q          <= '0;
      acc_q        <= '0;
      total_q      <= '0;
      lvl_q        <= '0;
      dig_q        <= '0;
      clr_q        <= '0;
      res_key_q    <= '0;
      res_rank_q   <= '0;
      res_status_q <= osm_pkg::ST_OK;
      out_valid_q  <= 1'b0;
      out_key_q    <= '0;
      out_rank_q   <= '0;
      out_status_q <= osm_pkg::ST_OK;
    end else begin
      // S_FIN refills the output register itself
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + osm_pkg::ADDR_W'(1);
          if (clr_q == osm_pkg::LAST_NODE) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q         <= osm_pkg::op_e'(in_operation_i);
            u_q          <= in_key_i ^ osm_pkg::SIGN_MASK;
            pos_q        <= in_position_i;
            res_key_q    <= '0;
            res_rank_q   <= '0;
            res_status_q <= osm_pkg::ST_OK;
            state_q      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          lvl_q    <= '0;
          dig_q    <= '0;
          acc_q    <= '0;
          prefix_q <= '0;
          unique case (op_q)
            osm_pkg::OP_INSERT: begin
              if (total_q >= osm_pkg::CAPACITY) begin
                res_status_q <= osm_pkg::ST_FULL;
                state_q      <= S_FIN;
              end else begin
                state_q <= S_RMW_RD;
              end
            end
            osm_pkg::OP_ERASE: begin
              lvl_q   <= LAST_LVL;
              state_q <= S_ER_RD;
            end
            osm_pkg::OP_RANK, osm_pkg::OP_PRED, osm_pkg::OP_SUCC: begin
              state_q <= S_LESS_RD;
            end
            osm_pkg::OP_SELECT: begin
              if (pos_q == '0 || osm_pkg::CNT_W'(pos_q) > total_q) begin
                res_status_q <= osm_pkg::ST_ABSENT;
                state_q      <= S_FIN;
              end else begin
                k_q     <= osm_pkg::CNT_W'(pos_q);
                state_q <= S_SEL_RD;
              end
            end
            default: begin
              res_status_q <= osm_pkg::ST_ABSENT;
              state_q      <= S_FIN;
            end
          endcase
        end
        S_RMW_RD: state_q <= S_RMW_WR;
        S_RMW_WR: begin
          if (lvl_q == LAST_LVL) begin
            total_q <= up ? total_q + osm_pkg::CNT_W'(1) : total_q - osm_pkg::CNT_W'(1);
            state_q <= S_FIN;
          end else begin
            lvl_q   <= lvl_q + osm_pkg::LVL_W'(1);
            state_q <= S_RMW_RD;
          end
        end
        S_ER_RD: state_q <= S_ER_CHK;
        S_ER_CHK: begin
          if (rdata_q == '0) begin
            res_status_q <= osm_pkg::ST_ABSENT;
            state_q      <= S_FIN;
          end else begin
            lvl_q   <= '0;
            state_q <= S_RMW_RD;
          end
        end
        S_LESS_RD: begin
          if (dig_q == udig) begin
            if (lvl_q == LAST_LVL) begin
              priority case (op_q)
                osm_pkg::OP_RANK: begin
                  res_rank_q <= osm_pkg::POS_W'(acc_q + osm_pkg::CNT_W'(1));
                  state_q    <= S_FIN;
                end
                osm_pkg::OP_PRED: begin
                  if (acc_q == '0) begin
                    res_status_q <= osm_pkg::ST_ABSENT;
                    state_q      <= S_FIN;
                  end else begin
                    k_q     <= acc_q;
                    lvl_q   <= '0;
                    dig_q   <= '0;
                    state_q <= S_SEL_RD;
                  end
                end
                default: state_q <= S_LEAF_RD;
              endcase
            end else begin
              lvl_q <= lvl_q + osm_pkg::LVL_W'(1);
              dig_q <= '0;
            end
          end else begin
            state_q <= S_LESS_ACC;
          end
        end
        S_LESS_ACC: begin
          acc_q   <= leaf_sum;
          dig_q   <= dig_q + osm_pkg::DIGIT_BITS'(1);
          state_q <= S_LESS_RD;
        end
        S_LEAF_RD: state_q <= S_LEAF_ACC;
        S_LEAF_ACC: begin
          if (leaf_sum >= total_q) begin
            res_status_q <= osm_pkg::ST_ABSENT;
            state_q      <= S_FIN;
          end else begin
            k_q     <= leaf_sum + osm_pkg::CNT_W'(1);
            lvl_q   <= '0;
            dig_q   <= '0;
            state_q <= S_SEL_RD;
          end
        end
        S_SEL_RD: state_q <= S_SEL_USE;
        S_SEL_USE: begin
          if (pick) begin
            // top digit taken without a fit: the second-to-last count is passed
            if (k_q > rdata_q) begin
              k_q <= k_q - rdata_q;
            end
            prefix_q <= next_prefix;
            dig_q    <= '0;
            if (lvl_q == LAST_LVL) begin
              res_key_q <= next_prefix ^ osm_pkg::SIGN_MASK;
              state_q   <= S_FIN;
            end else begin
              lvl_q   <= lvl_q + osm_pkg::LVL_W'(1);
              state_q <= S_SEL_RD;
            end
          end else begin
            k_q     <= k_q - rdata_q;
            dig_q   <= dig_q + osm_pkg::DIGIT_BITS'(1);
            state_q <= S_SEL_RD;
          end
        end
        S_FIN: begin
          // wait for the output register to free up
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_key_q    <= res_key_q;
            out_rank_q   <= res_rank_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_found_key_o = out_key_q;
  assign out_rank_o      = out_rank_q;
  assign out_status_o    = out_status_q;

endmodule

/* src/osm_checker.sv */
// ----------------------------------------------------------------------------
// osm_checker
// Port-level checks of the order statistic multiset core.
// ----------------------------------------------------------------------------
`include "order_statistic_multiset_core_assert.svh"

module osm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [osm_pkg::KEY_BITS-1:0]        out_found_key_o,
  input logic [osm_pkg::POS_W-1:0]           out_rank_o,
  input logic [osm_pkg::STAT_W-1:0]          out_status_o
);

  `OSM_ASSERT_NOW(a_status_code, out_valid_o, out_status_o != 2'd3, "bad status code")

  `OSM_ASSERT_NOW(a_rank_ok, out_valid_o && out_rank_o != '0, out_status_o == osm_pkg::ST_OK, "rank with error status")

  `OSM_ASSERT_NOW(a_key_ok, out_valid_o && out_found_key_o != '0, out_status_o == osm_pkg::ST_OK && out_rank_o == '0, "key with error status or rank")

  `OSM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_found_key_o) && $stable(out_rank_o) && $stable(out_status_o), "stalled result changed")

endmodule

bind order_statistic_multiset_core osm_checker u_osm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_found_key_o (out_found_key_o),
  .out_rank_o      (out_rank_o),
  .out_status_o    (out_status_o)
);

/* dv/order_statistic_multiset_core_test.sv */
// ----------------------------------------------------------------------------
// order_statistic_multiset_core_test
// Self-checking bench: a directed table, then weighted random operations.
// Each result is checked against a radix counting tree kept in the bench,
// while the sender and the receiver idle at random except in the last phase.
// ----------------------------------------------------------------------------
module order_statistic_multiset_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [osm_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [osm_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int RANDOM_PER_PHASE = 142;

  typedef struct {
    logic signed [osm_pkg::KEY_BITS-1:0] found_key;
    logic [osm_pkg::POS_W-1:0]           rank;
    logic [osm_pkg::STAT_W-1:0]          status;
  } answer_t;

  typedef struct {
    logic [osm_pkg::OP_W-1:0]            op;
    logic signed [osm_pkg::KEY_BITS-1:0] key;
    logic [osm_pkg::POS_W-1:0]           pos;
    bit                                  typed;
    answer_t                             ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [osm_pkg::OP_W-1:0] in_operation_i = '0;
  logic signed [osm_pkg::KEY_BITS-1:0] in_key_i = '0;
  logic [osm_pkg::POS_W-1:0] in_position_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [osm_pkg::KEY_BITS-1:0] out_found_key_o;
  logic [osm_pkg::POS_W-1:0] out_rank_o;
  logic [osm_pkg::STAT_W-1:0] out_status_o;

  order_statistic_multiset_core dut (.*);

  // per-level prefix counters, indexed by the key prefix down to that level
  int unsigned level_counts[osm_pkg::LEVELS][1 << osm_pkg::KEY_BITS];
  int unsigned stored_total;
  answer_t pending_answers[$];
  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  longint cycle_count = 0;
  logic signed [osm_pkg::KEY_BITS-1:0] key_pool[32];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned prefix_of(logic [osm_pkg::KEY_BITS-1:0] u, int lvl);
    return int'(u) >> (osm_pkg::DIGIT_BITS * (osm_pkg::LEVELS - 1 - lvl));
  endfunction

  function automatic int unsigned keys_below(logic [osm_pkg::KEY_BITS-1:0] u);
    int unsigned acc;
    int unsigned p;
    acc = 0;
    for (int l = 0; l < osm_pkg::LEVELS; l++) begin
      p = prefix_of(u, l);
      for (int unsigned j = p & ~(osm_pkg::RADIX - 1); j < p; j++) acc += level_counts[l][j];
    end
    return acc;
  endfunction

  function automatic logic signed [osm_pkg::KEY_BITS-1:0] kth_key(int unsigned k);
    int unsigned prefix;
    int d;
    prefix = 0;
    for (int l = 0; l < osm_pkg::LEVELS; l++) begin
      prefix = prefix << osm_pkg::DIGIT_BITS;
      for (d = 0; d < osm_pkg::RADIX - 1; d++) begin
        if (k <= level_counts[l][prefix + d]) break;
        k -= level_counts[l][prefix + d];
      end
      prefix += d;
    end
    return osm_pkg::KEY_BITS'(prefix) ^ osm_pkg::SIGN_MASK;
  endfunction

  function automatic answer_t apply_operation(logic [osm_pkg::OP_W-1:0] op,
                                              logic signed [osm_pkg::KEY_BITS-1:0] key,
                                              logic [osm_pkg::POS_W-1:0] pos);
    answer_t a;
    logic [osm_pkg::KEY_BITS-1:0] u;
    int unsigned below;
    int unsigned here;
    a = '{found_key: '0, rank: '0, status: osm_pkg::ST_OK};
    u = key ^ osm_pkg::SIGN_MASK;
    below = keys_below(u);
    here = level_counts[osm_pkg::LEVELS-1][u];
    case (op)
      osm_pkg::OP_INSERT: begin
        if (stored_total >= osm_pkg::CAPACITY) a.status = osm_pkg::ST_FULL;
        else begin
          for (int l = 0; l < osm_pkg::LEVELS; l++) level_counts[l][prefix_of(u, l)]++;
          stored_total++;
        end
      end
      osm_pkg::OP_ERASE: begin
        if (here == 0) a.status = osm_pkg::ST_ABSENT;
        else begin
          for (int l = 0; l < osm_pkg::LEVELS; l++) level_counts[l][prefix_of(u, l)]--;
          stored_total--;
        end
      end
      osm_pkg::OP_RANK: a.rank = osm_pkg::POS_W'(below + 1);
      osm_pkg::OP_SELECT: begin
        if (pos == 0 || pos > stored_total) a.status = osm_pkg::ST_ABSENT;
        else a.found_key = kth_key(pos);
      end
      osm_pkg::OP_PRED: begin
        if (below == 0) a.status = osm_pkg::ST_ABSENT;
        else a.found_key = kth_key(below);
      end
      osm_pkg::OP_SUCC: begin
        if (below + here >= stored_total) a.status = osm_pkg::ST_ABSENT;
        else a.found_key = kth_key(below + here + 1);
      end
      default: a.status = osm_pkg::ST_ABSENT;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // one transfer on the input channel, predicted at the accepting edge;
  // valid stays up until the next idle cycle or drain
  task automatic send_item(logic [osm_pkg::OP_W-1:0] op,
                           logic signed [osm_pkg::KEY_BITS-1:0] key,
                           logic [osm_pkg::POS_W-1:0] pos, bit typed, answer_t typed_ans);
    answer_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_operation_i <= op;
    in_key_i <= key;
    in_position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    a = apply_operation(op, key, pos);
    if (typed) begin
      if (a.found_key !== typed_ans.found_key)
        report_mismatch("table row found_key", a.found_key, typed_ans.found_key);
      if (a.rank !== typed_ans.rank)
        report_mismatch("table row rank", a.rank, typed_ans.rank);
      if (a.status !== typed_ans.status)
        report_mismatch("table row status", a.status, typed_ans.status);
    end
    pending_answers.push_back(a);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  task automatic random_item();
    logic [osm_pkg::OP_W-1:0] op;
    logic signed [osm_pkg::KEY_BITS-1:0] key;
    logic [osm_pkg::POS_W-1:0] pos;
    int r;
    r = $urandom_range(99);
    if (r < 32) op = osm_pkg::OP_INSERT;
    else if (r < 50) op = osm_pkg::OP_ERASE;
    else if (r < 62) op = osm_pkg::OP_RANK;
    else if (r < 76) op = osm_pkg::OP_SELECT;
    else if (r < 87) op = osm_pkg::OP_PRED;
    else if (r < 98) op = osm_pkg::OP_SUCC;
    else op = r[0] ? OP_SPARE_HI : OP_SPARE_LO;
    r = $urandom_range(99);
    if (r < 70) key = key_pool[$urandom_range(31)];
    else if (r < 74) key = r[0] ? 16'sh7fff : 16'sh8000;
    else key = osm_pkg::KEY_BITS'($urandom());
    if ($urandom_range(9) == 0) pos = osm_pkg::POS_W'($urandom());
    else pos = osm_pkg::POS_W'($urandom_range(stored_total + 2));
    send_item(op, key, pos, 1'b0, '{default: '0});
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_answers.size() == 0) report_mismatch("unexpected transfer", 1, 0);
        else begin
          want = pending_answers.pop_front();
          if (out_found_key_o !== want.found_key)
            report_mismatch("found_key", out_found_key_o, want.found_key);
          if (out_rank_o !== want.rank) report_mismatch("rank", out_rank_o, want.rank);
          if (out_status_o !== want.status) report_mismatch("status", out_status_o, want.status);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    row_t rows[$];
    error_count = 0;
    stored_total = 0;
    send_idle_pct = 17;
    recv_stall_pct = 64;
    foreach (level_counts[l, j]) level_counts[l][j] = 0;
    foreach (key_pool[i])
      key_pool[i] = osm_pkg::KEY_BITS'($urandom_range(40) - 20 + ((i % 4) * 9000) - 13000);

    rows = '{
      '{osm_pkg::OP_RANK,   16'sd5,    21'd0,      1, '{0, 1, osm_pkg::ST_OK}},
      '{osm_pkg::OP_PRED,   16'sd0,    21'd0,      1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{osm_pkg::OP_SUCC,   16'sh8000, 21'd0,      1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{osm_pkg::OP_SELECT, 16'sd0,    21'd1,      1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{osm_pkg::OP_ERASE,  16'sd7,    21'd0,      1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{OP_SPARE_LO,        16'sd1,    21'd1,      1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{OP_SPARE_HI,        16'sh7fff, 21'h1fffff, 1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{osm_pkg::OP_INSERT, 16'sh8000, 21'd0,      1, '{0, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_INSERT, 16'sh7fff, 21'h1fffff, 1, '{0, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_INSERT, 16'sd0,    21'd0,      1, '{0, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_INSERT, 16'sd0,    21'd0,      1, '{0, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_INSERT, -16'sd1,   21'd0,      1, '{0, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_RANK,   16'sh7fff, 21'd0,      1, '{0, 5, osm_pkg::ST_OK}},
      '{osm_pkg::OP_RANK,   16'sh8000, 21'd0,      1, '{0, 1, osm_pkg::ST_OK}},
      '{osm_pkg::OP_SELECT, 16'sd0,    21'd1,      1, '{16'sh8000, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_SELECT, 16'sd0,    21'd5,      1, '{16'sh7fff, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_SELECT, 16'sd0,    21'd0,      1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{osm_pkg::OP_SELECT, 16'sd0,    21'h1fffff, 1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{osm_pkg::OP_SUCC,   16'sh7fff, 21'd0,      1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{osm_pkg::OP_PRED,   16'sh8000, 21'd0,      1, '{0, 0, osm_pkg::ST_ABSENT}},
      '{osm_pkg::OP_ERASE,  16'sd0,    21'd0,      1, '{0, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_PRED,   16'sd0,    21'd0,      1, '{-16'sd1, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_SUCC,   16'sd0,    21'd0,      1, '{16'sh7fff, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_SUCC,   16'sh5555, 21'h0aaaaa, 0, '{0, 0, osm_pkg::ST_OK}},
      '{osm_pkg::OP_PRED,   16'shaaaa, 21'h155555, 0, '{0, 0, osm_pkg::ST_OK}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_item(rows[i].op, rows[i].key, rows[i].pos, rows[i].typed, rows[i].ans);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 64;
        recv_stall_pct = 17;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) random_item();
      // hold the sender off until every result is back
      drain_results();
    end

    repeat (300) @(posedge clk_i);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/osm_pkg.sv
src/order_statistic_multiset_core.sv
src/osm_checker.sv
dv/order_statistic_multiset_core_test.sv
